>>> rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W         = 16;
  localparam int MAX_BLOCKS_DEF = 32;
  localparam logic [ADDR_W-1:0] TOTAL_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_BADADDR = 3'd2,
    ST_FULL    = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  // one free segment
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } seg_t;

  // broadcast from the controller to every segment cell
  typedef struct packed {
    logic              alloc_go;
    logic              free_go;
    func_t             func;
    logic              exact;
    logic              jp;
    logic              jn;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  // per-cell findings returned to the controller
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_start;
    logic              exact;
    logic              jn;
    logic              jp;
  } flags_t;

endpackage

>>> rtl/ffa_seg_cell.sv
// ----------------------------------------------------------------------------
// ffa_seg_cell
// One entry of the sorted free-segment row; shifts with its neighbours.
// ----------------------------------------------------------------------------
module ffa_seg_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_init,
  input  logic [ffa_pkg::ADDR_W-1:0]   init_len,
  input  ffa_pkg::cmd_t                cmd,
  input  ffa_pkg::seg_t                left_seg,
  input  logic                         chain_in,
  input  ffa_pkg::seg_t                right_seg,
  input  logic                         right_lt,
  output ffa_pkg::seg_t                seg,
  output logic                         chain_out,
  output logic                         lt,
  output ffa_pkg::flags_t              flags
);

  localparam int W = ffa_pkg::ADDR_W;

  ffa_pkg::seg_t seg_next;
  logic fit, ge, mark, hit;

  always_comb begin
    fit  = seg.valid && (cmd.size <= seg.len);
    ge   = !seg.valid || (seg.start >= cmd.addr);
    lt   = seg.valid && (seg.start < cmd.addr);
    mark = (cmd.func == ffa_pkg::FN_FREE) ? ge : fit;
    chain_out = chain_in | mark;
    hit  = mark && !chain_in;

    flags.hit       = hit && (cmd.func == ffa_pkg::FN_ALLOC);
    flags.hit_start = flags.hit ? seg.start : '0;
    flags.exact     = flags.hit && (seg.len == cmd.size);
    flags.jn        = (cmd.func == ffa_pkg::FN_FREE) && hit && seg.valid &&
                      (({1'b0, cmd.addr} + {1'b0, cmd.size}) == {1'b0, seg.start});
    // last segment below the address, ending exactly on it
    flags.jp        = (cmd.func == ffa_pkg::FN_FREE) && lt && !right_lt &&
                      (({1'b0, seg.start} + {1'b0, seg.len}) == {1'b0, cmd.addr});
  end

  always_comb begin
    seg_next = seg;
    if (cmd.alloc_go) begin
      if (hit) begin
        if (flags.exact) begin
          seg_next = right_seg;
        end else begin
          seg_next.start = W'(seg.start + cmd.size);
          seg_next.len   = W'(seg.len - cmd.size);
        end
      end else if (chain_in && cmd.exact) begin
        seg_next = right_seg;
      end
    end else if (cmd.free_go) begin
      if (cmd.jp) begin
        if (flags.jp) begin
          seg_next.len = W'(seg.len + cmd.size + (cmd.jn ? right_seg.len : '0));
        end else if (cmd.jn && chain_out) begin
          seg_next = right_seg;
        end
      end else if (cmd.jn) begin
        if (hit) begin
          seg_next.start = cmd.addr;
          seg_next.len   = W'(seg.len + cmd.size);
        end
      end else begin
        if (hit) begin
          seg_next.valid = 1'b1;
          seg_next.start = cmd.addr;
          seg_next.len   = cmd.size;
        end else if (chain_in) begin
          seg_next = left_seg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= FIRST ? ffa_pkg::seg_t'{valid: 1'b1, start: '0, len: ffa_pkg::TOTAL_RESET}
                   : ffa_pkg::seg_t'('0);
    end else if (cfg_init) begin
      seg <= FIRST ? ffa_pkg::seg_t'{valid: 1'b1, start: '0, len: init_len}
                   : ffa_pkg::seg_t'('0);
    end else begin
      seg <= seg_next;
    end
  end

endmodule

>>> rtl/ffa_used_cell.sv
// ----------------------------------------------------------------------------
// ffa_used_cell
// One allocated-block entry with its own address match.
// ----------------------------------------------------------------------------
module ffa_used_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_init,
  input  logic                       load,
  input  logic                       clear,
  input  logic [ffa_pkg::ADDR_W-1:0] load_start,
  input  logic [ffa_pkg::ADDR_W-1:0] load_size,
  input  logic [ffa_pkg::ADDR_W-1:0] addr,
  output logic                       valid,
  output logic                       match,
  output logic [ffa_pkg::ADDR_W-1:0] size
);

  logic [ffa_pkg::ADDR_W-1:0] start;

  assign match = valid && (start == addr);

  always_ff @(posedge clk) begin
    if (rst || cfg_init) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start <= load_start;
      size  <= load_size;
    end
  end

endmodule

>>> rtl/first_fit_allocator_coalescing.sv
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing
// First-fit allocator over a row of free-segment cells and a used-block row.
// ----------------------------------------------------------------------------
// Execution: operands are captured on acceptance, then a compare-and-shift pass
//   across the segment row runs once the output can take the result.
// The next word is taken after the last executes, also while its result waits.
// Reset: one free segment (0, 65535), used table empty; a total_size write
//   reinitialises both tables on the clock edge that accepts it.
module first_fit_allocator_coalescing #(
  parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffa_pkg::ADDR_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [ffa_pkg::ADDR_W-1:0] request_size,
  input  logic [ffa_pkg::ADDR_W-1:0] free_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ffa_pkg::ADDR_W-1:0] block_address,
  output logic [2:0]                 status
);

  localparam int W      = ffa_pkg::ADDR_W;
  localparam int DEPTH  = MAX_BLOCKS + 1;
  localparam int SLOT_W = $clog2(MAX_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  ffa_pkg::func_t func_q;
  logic [W-1:0] size_q, addr_q;
  logic [W-1:0] total_size;
  logic cfg_init;

  ffa_pkg::seg_t   segs [DEPTH];
  ffa_pkg::flags_t flg  [DEPTH];
  logic [DEPTH:0]  chain;
  logic [DEPTH:0]  lts;
  logic [DEPTH-1:0] seg_valid;
  ffa_pkg::cmd_t   cmd;

  logic [MAX_BLOCKS-1:0] u_valid, u_match, u_load, u_clear;
  logic [W-1:0]          u_size [MAX_BLOCKS];
  logic [SLOT_W-1:0]     free_slot;
  logic [W-1:0]          match_size;
  logic                  used_full, any_match;

  logic any_fit, any_exact, any_jp, any_jn;
  logic [W-1:0] hit_start;
  ffa_pkg::status_t st;
  logic go, ok;

  assign cfg_ready = 1'b1;
  assign cfg_init  = cfg_valid && cfg_ready;
  assign in_ready  = (state == S_IDLE);
  assign go        = (state == S_EXEC) && (!out_valid || out_ready);

  // used table lookups
  always_comb begin
    free_slot  = '0;
    match_size = '0;
    any_match  = 1'b0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!u_valid[i]) free_slot = SLOT_W'(i);
    end
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (u_match[i] && !any_match) begin
        match_size = u_size[i];
        any_match  = 1'b1;
      end
    end
    used_full = &u_valid;
  end

  // reduce cell findings
  always_comb begin
    any_fit = 1'b0; any_exact = 1'b0; any_jp = 1'b0; any_jn = 1'b0;
    hit_start = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_fit   = any_fit | flg[i].hit;
      any_exact = any_exact | flg[i].exact;
      any_jp    = any_jp | flg[i].jp;
      any_jn    = any_jn | flg[i].jn;
      hit_start = hit_start | flg[i].hit_start;
      seg_valid[i] = segs[i].valid;
    end
  end

  always_comb begin
    if (func_q == ffa_pkg::FN_ALLOC) begin
      if (size_q == '0)  st = ffa_pkg::ST_ZERO;
      else if (used_full) st = ffa_pkg::ST_FULL;
      else if (!any_fit)  st = ffa_pkg::ST_NOFIT;
      else                st = ffa_pkg::ST_OK;
    end else begin
      if (!any_match) st = ffa_pkg::ST_BADADDR;
      else if (!any_jp && !any_jn && segs[DEPTH-1].valid) st = ffa_pkg::ST_FULL;
      else st = ffa_pkg::ST_OK;
    end
    ok = (st == ffa_pkg::ST_OK);
  end

  always_comb begin
    cmd.alloc_go = go && ok && (func_q == ffa_pkg::FN_ALLOC);
    cmd.free_go  = go && ok && (func_q == ffa_pkg::FN_FREE);
    cmd.func     = func_q;
    cmd.exact    = any_exact;
    cmd.jp       = any_jp;
    cmd.jn       = any_jn;
    cmd.size     = (func_q == ffa_pkg::FN_FREE) ? match_size : size_q;
    cmd.addr     = addr_q;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      u_load[i]  = cmd.alloc_go && (free_slot == SLOT_W'(i));
      u_clear[i] = cmd.free_go && u_match[i];
    end
  end

  assign chain[0]   = 1'b0;
  assign lts[DEPTH] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_seg
    ffa_pkg::seg_t lseg, rseg;
    assign lseg = (g == 0) ? '0 : segs[(g == 0) ? 0 : g - 1];
    assign rseg = (g == DEPTH - 1) ? '0 : segs[(g == DEPTH - 1) ? g : g + 1];
    ffa_seg_cell #(.FIRST(g == 0)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg_init  (cfg_init),
      .init_len  (cfg_data),
      .cmd       (cmd),
      .left_seg  (lseg),
      .chain_in  (chain[g]),
      .right_seg (rseg),
      .right_lt  (lts[g+1]),
      .seg       (segs[g]),
      .chain_out (chain[g+1]),
      .lt        (lts[g]),
      .flags     (flg[g])
    );
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_used
    ffa_used_cell u_used (
      .clk        (clk),
      .rst        (rst),
      .cfg_init   (cfg_init),
      .load       (u_load[g]),
      .clear      (u_clear[g]),
      .load_start (hit_start),
      .load_size  (size_q),
      .addr       (addr_q),
      .valid      (u_valid[g]),
      .match      (u_match[g]),
      .size       (u_size[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      total_size <= ffa_pkg::TOTAL_RESET;
    end else begin
      if (cfg_init) total_size <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q <= ffa_pkg::func_t'(func);
      size_q <= request_size;
      addr_q <= free_address;
    end
    if (go) begin
      status        <= st;
      block_address <= (ok && func_q == ffa_pkg::FN_ALLOC) ? hit_start : '0;
    end
  end

  // free segments always sit packed at the low end of the row
  a_seg_packed: assert property (@(posedge clk) disable iff (rst)
    ((seg_valid + DEPTH'(1)) & seg_valid) == '0)
    else $error("free segment row not contiguous");

  a_one_owner: assert property (@(posedge clk) disable iff (rst)
    $onehot0(u_match))
    else $error("two used blocks share a start address");

  a_exec_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted word not executed");

  a_result: assert property (@(posedge clk) disable iff (rst)
    go |=> (out_valid && (total_size == $past(total_size))))
    else $error("result lost");

endmodule

>>> tb/sv/first_fit_allocator_coalescing_test.sv
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_test
// Drives allocate and free words into the first-fit allocator, predicts each
// result from a free-segment list and used-block table kept here, and checks
// every result word field by field. Several range sizes are configured.
// ----------------------------------------------------------------------------
module first_fit_allocator_coalescing_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W = ffa_pkg::ADDR_W;
  localparam int NBLK   = ffa_pkg::MAX_BLOCKS_DEF;
  localparam int NSEG   = NBLK + 1;
  localparam int LIMIT  = 400000;
  localparam int NRAND  = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [ADDR_W-1:0] request_size = '0;
  logic [ADDR_W-1:0] free_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] block_address;
  logic [2:0] status;

  first_fit_allocator_coalescing u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [ADDR_W-1:0] addr;
    ffa_pkg::status_t  st;
  } alloc_result_t;

  // predictor state
  logic [ADDR_W-1:0] seg_start [NSEG];
  logic [ADDR_W-1:0] seg_len [NSEG];
  int                seg_cnt;
  logic [ADDR_W-1:0] blk_start [NBLK];
  logic [ADDR_W-1:0] blk_size [NBLK];
  bit                blk_live [NBLK];
  logic [ADDR_W-1:0] range_size;

  alloc_result_t pending_results[$];
  int  fails = 0;
  int  cycles = 0;
  bit  hold_off = 1'b0;
  bit  long_stall_req = 1'b0;
  bit  long_done = 1'b0;

  function automatic void reinit_tables(logic [ADDR_W-1:0] sz);
    range_size = sz;
    for (int i = 0; i < NSEG; i++) begin
      seg_start[i] = '0;
      seg_len[i] = '0;
    end
    for (int i = 0; i < NBLK; i++) blk_live[i] = 1'b0;
    seg_len[0] = sz;
    seg_cnt = 1;
  endfunction

  function automatic void drop_seg(int pos);
    for (int i = pos; i + 1 < seg_cnt; i++) begin
      seg_start[i] = seg_start[i+1];
      seg_len[i] = seg_len[i+1];
    end
    seg_cnt--;
    seg_start[seg_cnt] = '0;
    seg_len[seg_cnt] = '0;
  endfunction

  function automatic alloc_result_t predict_alloc(logic [ADDR_W-1:0] sz);
    alloc_result_t r;
    int slot;
    r.addr = '0;
    slot = -1;
    if (sz == 0) begin
      r.st = ffa_pkg::ST_ZERO;
      return r;
    end
    for (int i = 0; i < NBLK; i++)
      if (!blk_live[i] && slot < 0) slot = i;
    if (slot < 0) begin
      r.st = ffa_pkg::ST_FULL;
      return r;
    end
    for (int i = 0; i < seg_cnt; i++) begin
      if (sz <= seg_len[i]) begin
        blk_live[slot] = 1'b1;
        blk_start[slot] = seg_start[i];
        blk_size[slot] = sz;
        r.addr = seg_start[i];
        if (sz < seg_len[i]) begin
          seg_start[i] = seg_start[i] + sz;
          seg_len[i] = seg_len[i] - sz;
        end else begin
          drop_seg(i);
        end
        r.st = ffa_pkg::ST_OK;
        return r;
      end
    end
    r.st = ffa_pkg::ST_NOFIT;
    return r;
  endfunction

  function automatic ffa_pkg::status_t predict_free(logic [ADDR_W-1:0] a);
    int slot, pos;
    logic [ADDR_W-1:0] sz;
    bit jn, jp;
    slot = -1;
    pos = 0;
    for (int i = 0; i < NBLK; i++)
      if (blk_live[i] && blk_start[i] == a && slot < 0) slot = i;
    if (slot < 0) return ffa_pkg::ST_BADADDR;
    sz = blk_size[slot];
    while (pos < seg_cnt && seg_start[pos] < a) pos++;
    // adjacency sums are exact integers, no wrap
    jn = pos < seg_cnt && (32'(a) + 32'(sz)) == 32'(seg_start[pos]);
    jp = pos > 0 && (32'(seg_start[pos-1]) + 32'(seg_len[pos-1])) == 32'(a);
    if (!jn && !jp && seg_cnt >= NSEG) return ffa_pkg::ST_FULL;
    blk_live[slot] = 1'b0;
    if (jp) begin
      seg_len[pos-1] = seg_len[pos-1] + sz;
      if (jn) begin
        seg_len[pos-1] = seg_len[pos-1] + seg_len[pos];
        drop_seg(pos);
      end
    end else if (jn) begin
      seg_start[pos] = a;
      seg_len[pos] = seg_len[pos] + sz;
    end else begin
      for (int i = seg_cnt; i > pos; i--) begin
        seg_start[i] = seg_start[i-1];
        seg_len[i] = seg_len[i-1];
      end
      seg_start[pos] = a;
      seg_len[pos] = sz;
      seg_cnt++;
    end
    return ffa_pkg::ST_OK;
  endfunction

  // pick a live block address, or a random one if none is live
  function automatic logic [ADDR_W-1:0] live_addr();
    int live[$];
    for (int i = 0; i < NBLK; i++) if (blk_live[i]) live.push_back(i);
    if (live.size() == 0) return ADDR_W'($urandom);
    return blk_start[live[$urandom_range(live.size() - 1)]];
  endfunction

  // send one word; returns once accepted
  task automatic send_word(ffa_pkg::func_t f, logic [ADDR_W-1:0] sz,
                           logic [ADDR_W-1:0] a, bit check_fixed,
                           logic [ADDR_W-1:0] x_addr, ffa_pkg::status_t x_st);
    alloc_result_t r;
    func <= f;
    request_size <= sz;
    free_address <= a;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (f == ffa_pkg::FN_ALLOC) r = predict_alloc(sz);
    else begin
      r.st = predict_free(a);
      r.addr = '0;
    end
    if (check_fixed && (r.addr != x_addr || r.st != x_st)) begin
      $error("directed row: predictor gives addr %0d status %0d", r.addr, r.st);
      fails++;
    end
    pending_results.push_back(r);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [ADDR_W-1:0] sz);
    cfg_data <= sz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reinit_tables(sz);
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_result_t x;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word addr %0d status %0d", block_address, status);
        fails++;
      end else begin
        x = pending_results.pop_front();
        if (block_address !== x.addr) begin
          $error("block_address: expected %0d, actual %0d", x.addr, block_address);
          fails++;
        end
        if (status !== 3'(x.st)) begin
          $error("status: expected %0d, actual %0d", x.st, status);
          fails++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    int hold_cnt;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else if (long_stall_req && !hold_off && !long_done) begin
      hold_off <= 1'b1;
      long_done <= 1'b1;
      hold_cnt = 200;
      out_ready <= 1'b0;
    end else if (hold_off) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_off <= 1'b0;
      out_ready <= 1'b0;
    end else if ((cycles / 300) % 3 == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(3) != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("first_fit_allocator_coalescing_test failed");
      $finish;
    end
  end

  typedef struct {
    ffa_pkg::func_t    f;
    logic [ADDR_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    bit                fixed;
    logic [ADDR_W-1:0] x_addr;
    ffa_pkg::status_t  x_st;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{ffa_pkg::FN_ALLOC, 16'd0,    16'd0,    1, 16'd0,  ffa_pkg::ST_ZERO},
    '{ffa_pkg::FN_FREE,  16'd0,    16'd5,    1, 16'd0,  ffa_pkg::ST_BADADDR},
    '{ffa_pkg::FN_ALLOC, 16'd1,    16'd0,    1, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_ALLOC, 16'd10,   16'd0,    1, 16'd1,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_ALLOC, 16'd5,    16'd0,    1, 16'd11, ffa_pkg::ST_OK},
    '{ffa_pkg::FN_ALLOC, 16'hFFFF, 16'd0,    1, 16'd0,  ffa_pkg::ST_NOFIT},
    '{ffa_pkg::FN_FREE,  16'd0,    16'd1,    1, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_FREE,  16'd0,    16'd1,    1, 16'd0,  ffa_pkg::ST_BADADDR},
    '{ffa_pkg::FN_ALLOC, 16'd4,    16'd0,    0, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_FREE,  16'd0,    16'd0,    0, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_FREE,  16'd0,    16'd11,   0, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_FREE,  16'd0,    16'd5,    0, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_FREE,  16'd0,    16'hFFFF, 1, 16'd0,  ffa_pkg::ST_BADADDR},
    '{ffa_pkg::FN_ALLOC, 16'hFFFF, 16'hFFFF, 0, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_ALLOC, 16'd1,    16'd0,    1, 16'd0,  ffa_pkg::ST_OK},
    '{ffa_pkg::FN_FREE,  16'hFFFF, 16'd0,    0, 16'd0,  ffa_pkg::ST_OK}
  };

  initial begin
    int burst_left;
    reinit_tables(ffa_pkg::TOTAL_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].f, dir_rows[i].sz, dir_rows[i].a, dir_rows[i].fixed,
                dir_rows[i].x_addr, dir_rows[i].x_st);
    drain();

    // used table full: 33 one-unit allocations
    for (int i = 0; i < NBLK + 1; i++)
      send_word(ffa_pkg::FN_ALLOC, 16'd1, '0, i == NBLK, '0, ffa_pkg::ST_FULL);
    // fragment the free table: free every even address below NBLK
    for (int i = 0; i < NBLK; i += 2)
      send_word(ffa_pkg::FN_FREE, '0, ADDR_W'(i), 0, '0, ffa_pkg::ST_OK);
    drain();

    // zero total size, then a one-unit range
    write_size(16'd0);
    send_word(ffa_pkg::FN_ALLOC, 16'd1, '0, 1, '0, ffa_pkg::ST_NOFIT);
    drain();
    write_size(16'd1);
    send_word(ffa_pkg::FN_ALLOC, 16'd1, '0, 1, '0, ffa_pkg::ST_OK);
    send_word(ffa_pkg::FN_ALLOC, 16'd1, '0, 1, '0, ffa_pkg::ST_NOFIT);
    drain();

    // random phases over several range sizes
    burst_left = $urandom_range(1, 12);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_size(16'd64);
        1: write_size(16'd1000);
        2: write_size(16'hFFFF);
        3: write_size(ADDR_W'($urandom_range(2, 400)));
        default: write_size(16'd200);
      endcase
      for (int k = 0; k < NRAND / 5; k++) begin
        bit is_free;
        logic [ADDR_W-1:0] sz, a;
        is_free = $urandom_range(1);
        case ($urandom_range(9))
          0: sz = ADDR_W'($urandom);
          1: sz = '0;
          default: sz = ADDR_W'($urandom_range(1, (range_size / 8) + 1));
        endcase
        a = ($urandom_range(7) == 0) ? ADDR_W'($urandom) : live_addr();
        if (ph == 2 && k == 20) long_stall_req = 1'b1;
        send_word(is_free ? ffa_pkg::FN_FREE : ffa_pkg::FN_ALLOC, sz, a, 0, '0,
                  ffa_pkg::ST_OK);
        // bursts of random length, random gaps between them
        if (burst_left == 0) begin
          idle_gap();
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
        if (k == 60) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0)
      $display("first_fit_allocator_coalescing_test passed");
    else
      $display("first_fit_allocator_coalescing_test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/ffa_pkg.sv
rtl/ffa_seg_cell.sv
rtl/ffa_used_cell.sv
rtl/first_fit_allocator_coalescing.sv
tb/sv/first_fit_allocator_coalescing_test.sv
